// ===== src/weighted_polynomial_string_hash_macros.svh =====
// Assertion macros for the weighted polynomial string hash checker
`ifndef WEIGHTED_POLYNOMIAL_STRING_HASH_MACROS_SVH
`define WEIGHTED_POLYNOMIAL_STRING_HASH_MACROS_SVH

// same-cycle implication, disabled in reset
`define WPSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WPSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/wpsh_pkg.sv =====
// Package: types and constants of the weighted polynomial string hash
`timescale 1ns / 1ps
package wpsh_pkg;

    localparam int unsigned MAX_LENGTH = 65536;
    localparam int unsigned LEN_W      = 17;
    localparam int unsigned EXP_BITS   = 17;
    localparam int unsigned DIV_STEPS  = 64;
    localparam int unsigned CFG_W      = 64;
    localparam int unsigned CFG_ADDR_W = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_MB,
        ST_ME,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        SEL_SQ,
        SEL_BASE,
        SEL_ELEM
    } t_msel;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SALT,
        REG_TABLE_SIZE,
        REG_BYTE_MODE
    } t_reg;

    typedef enum logic [1:0] {
        PH_LO,
        PH_CROSS_A,
        PH_CROSS_B
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   mul_en;
        t_phase mul_ph;
        t_msel  msel;
        logic   exp_shift;
        logic   div_step;
        logic   finish;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic exp_msb;
        logic last;
        logic out_busy;
    } t_status;

endpackage

// ===== src/weighted_polynomial_string_hash.sv =====
// Top level of the weighted polynomial string hash
//
// Input channel: i_in_valid / o_in_ready carry one string element per request
// (i_element, i_string_length, i_first). i_first starts a new string and gives
// its length; a length of zero counts as one, a length above MAX_LENGTH is
// saturated and reported on o_length_clipped.
// Output channel: o_out_valid / i_out_ready carry one hash per string, after
// its last element.
// Configuration: i_cfg_we writes salt, table_size or byte_mode by index.
// Steps: once accepted, an element runs a 17-bit exponent walk of squarings and
// salt multiplies, the element product, a restoring modulo and a finish step, all
// on the shared 32x32 multiplier and the one-bit-per-cycle divider. The hash is
// registered at the finish of the last element of a string. Elements outside a
// string are taken and dropped. Reset (synchronous) restores the register
// defaults and clears the controller, accumulator, string position and length
// and output valid; the working registers and the hash register are not reset.
// A stalled receiver holds the hash; the next element is still taken and
// worked on, waiting at its finish only if it is the last of its string.
`timescale 1ns / 1ps
module weighted_polynomial_string_hash
    import wpsh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_element,
    input  logic [LEN_W-1:0]      i_string_length,
    input  logic                  i_first,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_hash,
    output logic                  o_length_clipped
);

    t_cmd    cmd;
    t_status status;

    wpsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    wpsh_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_element        (i_element),
        .i_string_length  (i_string_length),
        .i_first          (i_first),
        .i_out_ready      (i_out_ready),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_hash           (o_hash),
        .o_length_clipped (o_length_clipped)
    );

endmodule

// ===== src/wpsh_ctrl.sv =====
// Controller: sequences power, multiply and modulo steps for one request
`timescale 1ns / 1ps
module wpsh_ctrl
    import wpsh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    localparam int unsigned BIT_W = $clog2(EXP_BITS);
    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    t_state           r_state, n_state;
    t_phase           r_ph, n_ph;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= PH_LO;
            r_bit   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_bit   <= n_bit;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ph       = r_ph;
        n_bit      = r_bit;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_ph = r_ph;
        o_cmd.msel   = SEL_SQ;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_ph  = PH_LO;
                n_bit = '0;
                if (i_in_valid && !i_status.drop) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQ;
                end
            end
            ST_SQ, ST_MB: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = (r_state == ST_SQ) ? SEL_SQ : SEL_BASE;
                if (r_ph == PH_CROSS_B) begin
                    n_ph = PH_LO;
                    if (r_state == ST_SQ && i_status.exp_msb) begin
                        n_state = ST_MB;
                    end else begin
                        o_cmd.exp_shift = 1'b1;
                        if (r_bit == BIT_W'(EXP_BITS - 1)) begin
                            n_state = ST_ME;
                        end else begin
                            n_bit   = r_bit + 1'b1;
                            n_state = ST_SQ;
                        end
                    end
                end else begin
                    n_ph = t_phase'(r_ph + 1'b1);
                end
            end
            ST_ME: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = SEL_ELEM;
                if (r_ph == PH_CROSS_B) begin
                    n_ph    = PH_LO;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_ph = t_phase'(r_ph + 1'b1);
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_status.last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else if (!i_status.out_busy) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/wpsh_dp.sv =====
// Datapath: configuration, shared 32x32 multiplier, restoring divider, output register
`timescale 1ns / 1ps
module wpsh_dp
    import wpsh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic [31:0]           i_element,
    input  logic [LEN_W-1:0]      i_string_length,
    input  logic                  i_first,
    input  logic                  i_out_ready,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    output logic [31:0]           o_hash,
    output logic                  o_length_clipped
);

    logic [63:0]         r_salt;
    logic [31:0]         r_tsize;
    logic                r_byte_mode;
    logic [31:0]         r_acc;
    logic [LEN_W-1:0]    r_pos;
    logic [LEN_W-1:0]    r_len;
    logic                r_clip;
    logic [63:0]         r_e;
    logic [EXP_BITS-1:0] r_exp;
    logic [63:0]         r_pow;
    logic [63:0]         r_plo;
    logic [31:0]         r_cross;
    logic [63:0]         r_dvd;
    logic [31:0]         r_rem;
    logic                r_ovalid;
    logic [31:0]         r_hash;
    logic                r_oclip;

    logic [24:0]         in_len_wide;
    logic                in_clip;
    logic [LEN_W-1:0]    in_len_nz;
    logic [LEN_W-1:0]    in_len_eff;
    logic [63:0]         in_e;
    logic [63:0]         mb_full;
    logic [31:0]         ma, mb;
    logic [63:0]         mp;
    logic [31:0]         cross_sum;
    logic [63:0]         prod;
    logic [31:0]         modv;
    logic [32:0]         trial;
    logic [LEN_W:0]      pos_inc;

    always_comb begin
        in_len_nz   = (i_string_length == '0) ? LEN_W'(1) : i_string_length;
        in_len_wide = 25'(in_len_nz);
        in_clip     = in_len_wide > 25'(MAX_LENGTH);
        in_len_eff  = in_clip ? LEN_W'(MAX_LENGTH) : in_len_nz;
        in_e        = r_byte_mode ? {{56{i_element[7]}}, i_element[7:0]}
                                  : {32'd0, i_element};
        case (i_cmd.msel)
            SEL_SQ:   mb_full = r_pow;
            SEL_BASE: mb_full = r_salt;
            SEL_ELEM: mb_full = r_e;
            default:  mb_full = r_pow;
        endcase
        case (i_cmd.mul_ph)
            PH_LO: begin
                ma = r_pow[31:0];
                mb = mb_full[31:0];
            end
            PH_CROSS_A: begin
                ma = r_pow[31:0];
                mb = mb_full[63:32];
            end
            PH_CROSS_B: begin
                ma = r_pow[63:32];
                mb = mb_full[31:0];
            end
            default: begin
                ma = r_pow[31:0];
                mb = mb_full[31:0];
            end
        endcase
        mp        = ma * mb;
        cross_sum = r_cross + mp[31:0];
        prod      = r_plo + {cross_sum, 32'd0};
        modv      = (r_tsize == '0) ? 32'd1 : r_tsize;
        trial     = {r_rem, r_dvd[63]};
        pos_inc   = {1'b0, r_pos} + 1'b1;

        o_status.drop     = !i_first && (r_pos >= r_len);
        o_status.exp_msb  = r_exp[EXP_BITS-1];
        o_status.last     = pos_inc >= {1'b0, r_len};
        o_status.out_busy = r_ovalid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt      <= 64'd31;
            r_tsize     <= 32'd4096;
            r_byte_mode <= 1'b1;
            r_acc       <= '0;
            r_pos       <= '0;
            r_len       <= '0;
            r_clip      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_addr))
                    REG_SALT:       r_salt      <= i_cfg_wdata;
                    REG_TABLE_SIZE: r_tsize     <= i_cfg_wdata[31:0];
                    REG_BYTE_MODE:  r_byte_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_cmd.load && i_first) begin
                r_acc  <= '0;
                r_pos  <= '0;
                r_len  <= in_len_eff;
                r_clip <= in_clip;
            end
            if (i_cmd.finish) begin
                r_acc <= r_rem;
                r_pos <= pos_inc[LEN_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e   <= in_e;
            r_pow <= 64'd1;
            if (i_first) begin
                r_exp <= EXP_BITS'(in_len_eff) + 1'b1;
            end else begin
                r_exp <= EXP_BITS'(r_len - r_pos) + 1'b1;
            end
        end
        if (i_cmd.exp_shift) begin
            r_exp <= {r_exp[EXP_BITS-2:0], 1'b0};
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_ph)
                PH_LO:      r_plo   <= mp;
                PH_CROSS_A: r_cross <= mp[31:0];
                PH_CROSS_B: begin
                    if (i_cmd.msel == SEL_ELEM) begin
                        r_dvd <= prod + {32'd0, r_acc};
                        r_rem <= '0;
                    end else begin
                        r_pow <= prod;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            if (trial >= {1'b0, modv}) begin
                r_rem <= 32'(trial - {1'b0, modv});
            end else begin
                r_rem <= trial[31:0];
            end
        end
        if (i_cmd.out_load) begin
            r_hash  <= r_rem;
            r_oclip <= r_clip;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_hash           = r_hash;
    assign o_length_clipped = r_oclip;

endmodule

// ===== src/wpsh_checker.sv =====
// Checker: port-level assertions for the weighted polynomial string hash
`timescale 1ns / 1ps
`include "weighted_polynomial_string_hash_macros.svh"
module wpsh_checker
    import wpsh_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_first,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_hash
);

    `WPSH_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "hash dropped under stall")
    `WPSH_ASSERT_NEXT(a_hash_hold, o_out_valid && !i_out_ready, $stable(o_hash), "hash changed under stall")
    `WPSH_ASSERT_NEXT(a_busy_after_first, i_in_valid && o_in_ready && i_first, !o_in_ready, "ready right after string start")
    `WPSH_ASSERT_NOW(a_busy_two, $past(i_in_valid && o_in_ready && i_first, 2) && $past(i_rst_n, 2) && $past(i_rst_n), !o_in_ready, "element finished too early")

endmodule

bind weighted_polynomial_string_hash wpsh_checker u_wpsh_checker (.*);
